>>> src/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned IW_W     = 12;
	localparam int unsigned IH_W     = 13;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned OCOL_W   = 11;
	localparam int unsigned CFG_W    = 13;
	localparam int unsigned GRAD_W   = 10;
	localparam int unsigned SUM_W    = 21;
	localparam int unsigned ROOT_W   = 8;

	localparam logic [IW_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [IH_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [IH_W-1:0] MIN_SIZE_H   = 13'd3;
	localparam logic [IH_W-1:0] MAX_HEIGHT   = 13'd4096;
	localparam logic [PIX_W-1:0] SAT_VALUE   = 8'd255;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic root;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic emit_req;
		logic interior;
		logic root_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> src/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl
// Sequencer: load window; where a result is due, square, sum, iterate root and emit one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire sgm_pkg::stat_t stat,
	output sgm_pkg::cmd_t       cmd,
	output logic                in_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					priority if (!stat.emit_req) state_q <= ST_IDLE;
					else if (!stat.interior) state_q <= ST_EMIT;
					else state_q <= ST_SQUARE;
				end
				ST_SQUARE: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_ROOT;
				ST_ROOT: begin
					if (stat.root_last) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.square = (state_q == ST_SQUARE);
	assign cmd.sum    = (state_q == ST_SUM);
	assign cmd.root   = (state_q == ST_ROOT);
	assign cmd.emit   = (state_q == ST_EMIT);

endmodule

`default_nettype wire

>>> src/sgm_datapath.sv
// ----------------------------------------------------------------------------
// sgm_datapath
// Position counters, line store, 3x3 window, gradient, root, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_datapath #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic [sgm_pkg::PIX_W-1:0]    pixel,
	input  wire logic                         cfg_write,
	input  wire logic                         cfg_index,
	input  wire logic [sgm_pkg::CFG_W-1:0]    cfg_data,
	input  wire sgm_pkg::cmd_t                cmd,
	output sgm_pkg::stat_t                    stat,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic [sgm_pkg::PIX_W-1:0]         edge_value,
	output logic [sgm_pkg::ROW_W-1:0]         out_row,
	output logic [sgm_pkg::OCOL_W-1:0]        out_col
);

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WW  = (WB > sgm_pkg::IW_W) ? WB : sgm_pkg::IW_W;
	localparam int unsigned OCW = (CW > sgm_pkg::OCOL_W) ? CW : sgm_pkg::OCOL_W;
	localparam int unsigned PW  = sgm_pkg::PIX_W;
	localparam int unsigned GW  = sgm_pkg::GRAD_W;
	localparam int unsigned RW  = sgm_pkg::ROOT_W;

	logic [sgm_pkg::IW_W-1:0]  width_q;
	logic [sgm_pkg::IH_W-1:0]  height_q;
	logic [CW-1:0]             col_q;
	logic [sgm_pkg::ROW_W-1:0] row_q;
	logic [CW-1:0]             c_q;
	logic [sgm_pkg::ROW_W-1:0] r_q;
	logic [PW-1:0]             pix_q;
	logic [2*PW-1:0]           line_mem [MAX_WIDTH];
	logic [2*PW-1:0]           rd_q;
	logic [PW-1:0]             win_q [6];
	logic [GW-1:0]             ax_q, ay_q;
	logic [2*GW-1:0]           sqx_q, sqy_q;
	logic [2*RW-1:0]           sum_q;
	logic                      sat_q;
	logic [RW-1:0]             res_q;
	logic [RW-1:0]             bit_q;
	logic                      out_valid_q;
	logic [PW-1:0]             edge_q;
	logic [sgm_pkg::ROW_W-1:0] orow_q;
	logic [sgm_pkg::OCOL_W-1:0] ocol_q;

	// effective frame size
	logic [WW-1:0]             w_raw, w_eff;
	logic [sgm_pkg::IH_W-1:0]  h_eff;
	always_comb begin
		w_raw = WW'(width_q);
		priority if (w_raw < WW'(3)) w_eff = WW'(3);
		else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = w_raw;
		priority if (height_q < sgm_pkg::MIN_SIZE_H) h_eff = sgm_pkg::MIN_SIZE_H;
		else if (height_q > sgm_pkg::MAX_HEIGHT) h_eff = sgm_pkg::MAX_HEIGHT;
		else h_eff = height_q;
	end

	// position of the incoming pixel and the one after it
	logic                      col_wrap;
	logic [CW-1:0]             c_n;
	logic [sgm_pkg::IH_W-1:0]  r1;
	logic [sgm_pkg::ROW_W-1:0] r_n;
	logic [sgm_pkg::IH_W-1:0]  r_inc;
	logic [CW-1:0]             col_nx;
	logic [sgm_pkg::ROW_W-1:0] row_nx;
	always_comb begin
		col_wrap = (WW'(col_q) >= w_eff);
		c_n      = col_wrap ? '0 : col_q;
		r1       = col_wrap ? (sgm_pkg::IH_W'(row_q) + 13'd1) : sgm_pkg::IH_W'(row_q);
		r_n      = (r1 >= h_eff) ? '0 : r1[sgm_pkg::ROW_W-1:0];
		r_inc    = sgm_pkg::IH_W'(r_n) + 13'd1;
		if ((WW'(c_n) + WW'(1)) >= w_eff) begin
			col_nx = '0;
			row_nx = (r_inc >= h_eff) ? '0 : r_inc[sgm_pkg::ROW_W-1:0];
		end else begin
			col_nx = c_n + CW'(1);
			row_nx = r_n;
		end
	end

	// window and gradients
	logic [PW-1:0]     top, mid;
	logic signed [GW+1:0] gx, gy;
	logic [GW-1:0]     ax, ay;
	always_comb begin
		top = (r_q == '0) ? '0 : rd_q[2*PW-1:PW];
		mid = (r_q == '0) ? '0 : rd_q[PW-1:0];
		gx  = ($signed({4'b0, top}) + $signed({3'b0, mid, 1'b0}) + $signed({4'b0, pix_q}))
		    - ($signed({4'b0, win_q[0]}) + $signed({3'b0, win_q[1], 1'b0})
		    + $signed({4'b0, win_q[2]}));
		gy  = ($signed({4'b0, win_q[2]}) + $signed({3'b0, win_q[5], 1'b0})
		    + $signed({4'b0, pix_q}))
		    - ($signed({4'b0, win_q[0]}) + $signed({3'b0, win_q[3], 1'b0})
		    + $signed({4'b0, top}));
		ax  = gx[GW+1] ? GW'(-gx) : gx[GW-1:0];
		ay  = gy[GW+1] ? GW'(-gy) : gy[GW-1:0];
	end

	logic [sgm_pkg::SUM_W-1:0] sum_full;
	logic [RW-1:0]             trial;
	logic [2*RW-1:0]           trial_sq;
	logic [OCW-1:0]            cm1;
	always_comb begin
		sum_full = sgm_pkg::SUM_W'(sqx_q) + sgm_pkg::SUM_W'(sqy_q);
		trial    = res_q | bit_q;
		trial_sq = trial * trial;
		cm1      = OCW'(c_q) - OCW'(1);
	end

	assign stat.emit_req  = (r_q != '0) && (c_q != '0);
	assign stat.interior  = (r_q >= sgm_pkg::ROW_W'(2)) && (c_q >= CW'(2));
	assign stat.root_last = bit_q[0];
	assign stat.out_free  = !out_valid_q || !out_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgm_pkg::WIDTH_RESET;
			height_q <= sgm_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sgm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[sgm_pkg::IW_W-1:0];
				sgm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			c_q   <= '0;
			r_q   <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			if (take) begin
				col_q <= col_nx;
				row_q <= row_nx;
				c_q   <= c_n;
				r_q   <= r_n;
			end
			if (cmd.load) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top;
				win_q[4] <= mid;
				win_q[5] <= pix_q;
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (take) rd_q <= line_mem[c_n];
		if (cmd.load) line_mem[c_q] <= {mid, pix_q};
	end

	// arithmetic
	always_ff @(posedge clk) begin
		if (take) pix_q <= pixel;
		if (cmd.load) begin
			ax_q  <= ax;
			ay_q  <= ay;
			res_q <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.square) begin
			sqx_q <= ax_q * ax_q;
			sqy_q <= ay_q * ay_q;
		end
		if (cmd.sum) begin
			sum_q <= sum_full[2*RW-1:0];
			sat_q <= (sum_full[sgm_pkg::SUM_W-1:2*RW] != '0);
			bit_q <= {1'b1, {(RW-1){1'b0}}};
		end
		if (cmd.root) begin
			if (trial_sq <= sum_q) res_q <= trial;
			bit_q <= bit_q >> 1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && stat.out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && stat.out_free) begin
			edge_q <= sat_q ? sgm_pkg::SAT_VALUE : res_q;
			orow_q <= r_q - sgm_pkg::ROW_W'(1);
			ocol_q <= cm1[sgm_pkg::OCOL_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;
	assign out_row    = orow_q;
	assign out_col    = ocol_q;

endmodule

`default_nettype wire

>>> src/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel gradient magnitude over a raster pixel stream, saturated to 255.
// ----------------------------------------------------------------------------
// An accepted interior pixel goes through load, square, sum, an 8-step bit-serial
// square root and emit; other border positions go through load and emit, and the
// first row and column through load only. No new pixel is taken until the block
// is back in idle, so a held result beat also holds off the input.
// Reset clears position counters, window and output valid and sets the size to
// 640x480; the line store is not cleared.
`default_nettype none

module sobel_gradient_magnitude #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sgm_pkg::PIX_W-1:0]     pixel,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sgm_pkg::PIX_W-1:0]          edge_value,
	output logic [sgm_pkg::ROW_W-1:0]          out_row,
	output logic [sgm_pkg::OCOL_W-1:0]         out_col,
	input  wire logic                          cfg_write,
	input  wire logic                          cfg_index,
	input  wire logic [sgm_pkg::CFG_W-1:0]     cfg_data
);

	sgm_pkg::cmd_t  cmd;
	sgm_pkg::stat_t stat;
	logic           take;

	assign take = in_valid && !in_stall;

	sgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	sgm_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel      (pixel),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.edge_value (edge_value),
		.out_row    (out_row),
		.out_col    (out_col)
	);

endmodule

`default_nettype wire

>>> tb/sv/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_tb
// Self-checking bench for the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
// Streams pixels through the block and keeps its own model of the line
// stores, the window and the position counters. The model predicts every
// result beat, and each beat that comes out is compared with the oldest
// prediction. A short table of hand-made 3x3 frames comes first. The bench
// then grows and shrinks the line in mid-frame and runs an oversized frame.
// After that come random frame sizes, some out of range and some changed in
// mid-frame, each with random pixel content; a width that grows in mid-frame
// stays within the line store columns already written. Both sides idle at
// random. The receiver holds off once for a long stretch so that the block
// backs up.
// ----------------------------------------------------------------------------

module sobel_gradient_magnitude_tb;

	localparam int FRAME_MAX_W   = 2048;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_ITEMS  = 1060;
	localparam int PRESSURE_AT   = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_FROM    = 600;
	localparam int QUIET_TO      = 900;

	typedef struct packed {
		logic [sgm_pkg::PIX_W-1:0]  mag;
		logic [sgm_pkg::ROW_W-1:0]  row;
		logic [sgm_pkg::OCOL_W-1:0] col;
	} edge_beat_t;

	typedef enum logic [2:0] {
		DIR_WIDTH,
		DIR_HEIGHT,
		DIR_QUIET,
		DIR_GIVEN,
		DIR_MODEL
	} dir_kind_t;

	typedef struct packed {
		dir_kind_t                 kind;
		logic [sgm_pkg::CFG_W-1:0] value;
		edge_beat_t                want;
	} dir_row_t;

	typedef enum logic [1:0] {
		STYLE_NOISE,
		STYLE_BINARY,
		STYLE_SMOOTH,
		STYLE_STEPS
	} pix_style_t;

	// Two 3x3 frames at the clamped minimum size: a full-scale horizontal ramp of
	// 0, 128, 255 on every row, then a frame that falls from 255 on top to near 0 below.
	localparam dir_row_t DIR_ROWS [20] = '{
		'{DIR_WIDTH,  13'd1,   '0},
		'{DIR_HEIGHT, 13'd0,   '0},
		'{DIR_QUIET,  13'd0,   '0},
		'{DIR_QUIET,  13'd128, '0},
		'{DIR_QUIET,  13'd255, '0},
		'{DIR_QUIET,  13'd0,   '0},
		'{DIR_GIVEN,  13'd128, '{8'd0,   12'd0, 11'd0}},
		'{DIR_GIVEN,  13'd255, '{8'd0,   12'd0, 11'd1}},
		'{DIR_QUIET,  13'd0,   '0},
		'{DIR_GIVEN,  13'd128, '{8'd0,   12'd1, 11'd0}},
		'{DIR_GIVEN,  13'd255, '{8'd255, 12'd1, 11'd1}},
		'{DIR_MODEL,  13'd255, '0},
		'{DIR_MODEL,  13'd255, '0},
		'{DIR_MODEL,  13'd255, '0},
		'{DIR_MODEL,  13'd77,  '0},
		'{DIR_MODEL,  13'd0,   '0},
		'{DIR_MODEL,  13'd200, '0},
		'{DIR_MODEL,  13'd0,   '0},
		'{DIR_MODEL,  13'd0,   '0},
		'{DIR_MODEL,  13'd1,   '0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [sgm_pkg::PIX_W-1:0]    pixel;
	logic                         out_valid;
	logic                         out_stall;
	logic [sgm_pkg::PIX_W-1:0]    edge_value;
	logic [sgm_pkg::ROW_W-1:0]    out_row;
	logic [sgm_pkg::OCOL_W-1:0]   out_col;
	logic                         cfg_write;
	logic                         cfg_index;
	logic [sgm_pkg::CFG_W-1:0]    cfg_data;

	edge_beat_t                   pending_edges [$];
	int                           mismatch_count = 0;
	int                           pix_sent = 0;
	int                           got_count = 0;
	logic [sgm_pkg::PIX_W-1:0]    last_pix = '0;

	logic [sgm_pkg::IW_W-1:0]     size_w = sgm_pkg::WIDTH_RESET;
	logic [sgm_pkg::IH_W-1:0]     size_h = sgm_pkg::HEIGHT_RESET;
	logic [15:0]                  line_mem [FRAME_MAX_W];
	int                           col_a [3] = '{0, 0, 0};
	int                           col_b [3] = '{0, 0, 0};
	int unsigned                  cur_col = 0;
	int unsigned                  cur_row = 0;
	int unsigned                  fill_w = 0;

	sobel_gradient_magnitude #(
		.MAX_WIDTH(FRAME_MAX_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_value (edge_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("sobel_gradient_magnitude test failed");
		$finish;
	end

	function automatic bit quiet_window();
		return pix_sent >= QUIET_FROM && pix_sent < QUIET_TO;
	endfunction

	function automatic bit sobel_predict(input logic [sgm_pkg::PIX_W-1:0] pix,
			output edge_beat_t res);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int          top;
		int          mid;
		int          bot;
		int          gx;
		int          gy;
		int          energy;
		int          root;
		bit          emit;
		w = 32'(size_w);
		if (w < 3) w = 3;
		if (w > FRAME_MAX_W) w = FRAME_MAX_W;
		h = 32'(size_h);
		if (h < 32'(sgm_pkg::MIN_SIZE_H)) h = 32'(sgm_pkg::MIN_SIZE_H);
		if (h > 32'(sgm_pkg::MAX_HEIGHT)) h = 32'(sgm_pkg::MAX_HEIGHT);
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= h) cur_row = 0;
		c = cur_col;
		r = cur_row;
		bot = 32'(pix);
		if (r == 0) begin
			top = 0;
			mid = 0;
		end else begin
			top = 32'(line_mem[c][15:8]);
			mid = 32'(line_mem[c][7:0]);
		end
		res = '0;
		emit = (r >= 1 && c >= 1);
		if (emit) begin
			if (r >= 2 && c >= 2) begin
				gx = (top + 2 * mid + bot) - (col_a[0] + 2 * col_a[1] + col_a[2]);
				gy = (col_a[2] + 2 * col_b[2] + bot) - (col_a[0] + 2 * col_b[0] + top);
				energy = gx * gx + gy * gy;
				if (energy >= 65536) begin
					res.mag = sgm_pkg::SAT_VALUE;
				end else begin
					root = 0;
					while ((root + 1) * (root + 1) <= energy) root++;
					res.mag = sgm_pkg::PIX_W'(root);
				end
			end
			res.row = sgm_pkg::ROW_W'(r - 1);
			res.col = sgm_pkg::OCOL_W'(c - 1);
		end
		col_a = col_b;
		col_b = '{top, mid, bot};
		line_mem[c] = {8'(mid), pix};
		if (c + 1 > fill_w) fill_w = c + 1;
		if (c + 1 >= w) begin
			cur_col = 0;
			cur_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
		end
		return emit;
	endfunction

	function automatic bit width_reads_unwritten(input logic [sgm_pkg::CFG_W-1:0] w_data,
			input logic [sgm_pkg::CFG_W-1:0] h_data, input bit do_w, input bit do_h);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		w = do_w ? 32'(w_data[sgm_pkg::IW_W-1:0]) : 32'(size_w);
		h = do_h ? 32'(h_data[sgm_pkg::IH_W-1:0]) : 32'(size_h);
		if (w < 3) w = 3;
		if (w > FRAME_MAX_W) w = FRAME_MAX_W;
		if (h < 32'(sgm_pkg::MIN_SIZE_H)) h = 32'(sgm_pkg::MIN_SIZE_H);
		if (h > 32'(sgm_pkg::MAX_HEIGHT)) h = 32'(sgm_pkg::MAX_HEIGHT);
		r = cur_row;
		if (cur_col >= w) r++;
		if (r >= h) r = 0;
		return r != 0 && w > fill_w;
	endfunction

	function automatic logic [sgm_pkg::PIX_W-1:0] next_pixel(input pix_style_t style,
			input logic [sgm_pkg::PIX_W-1:0] prev);
		int v;
		if ($urandom_range(19) == 0) return sgm_pkg::PIX_W'($urandom_range(255));
		case (style)
			STYLE_BINARY: v = $urandom_range(1) ? 255 : 0;
			STYLE_SMOOTH: begin
				v = int'(prev) + int'($urandom_range(8)) - 4;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
			end
			STYLE_STEPS: v = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'(prev);
			default: v = $urandom_range(255);
		endcase
		return sgm_pkg::PIX_W'(v);
	endfunction

	task automatic feed_pixel(input logic [sgm_pkg::PIX_W-1:0] pix, output bit emitted,
			output edge_beat_t res);
		if (!quiet_window()) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		pixel <= pix;
		do @(posedge clk); while (in_stall);
		pix_sent++;
		emitted = sobel_predict(pix, res);
	endtask

	task automatic run_pixels(input int n, input pix_style_t style);
		bit         emitted;
		edge_beat_t res;
		for (int i = 0; i < n; i++) begin
			last_pix = next_pixel(style, last_pix);
			feed_pixel(last_pix, emitted, res);
			if (emitted) pending_edges.push_back(res);
		end
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [sgm_pkg::CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == sgm_pkg::REG_IMAGE_WIDTH) size_w = data[sgm_pkg::IW_W-1:0];
		else size_h = data[sgm_pkg::IH_W-1:0];
		@(posedge clk);
	endtask

	task automatic resize(input logic [sgm_pkg::CFG_W-1:0] w_data,
			input logic [sgm_pkg::CFG_W-1:0] h_data, input bit do_w, input bit do_h);
		drain_block();
		if (do_w) write_reg(sgm_pkg::REG_IMAGE_WIDTH, w_data);
		if (do_h) write_reg(sgm_pkg::REG_IMAGE_HEIGHT, h_data);
	endtask

	task automatic check_edge();
		edge_beat_t want;
		got_count++;
		if (pending_edges.size() == 0) begin
			$display("%0t: unexpected beat: edge_value %0d out_row %0d out_col %0d",
				$time, edge_value, out_row, out_col);
			mismatch_count++;
		end else begin
			want = pending_edges.pop_front();
			if (edge_value !== want.mag) begin
				$display("%0t: edge_value expected %0d got %0d", $time, want.mag, edge_value);
				mismatch_count++;
			end
			if (out_row !== want.row) begin
				$display("%0t: out_row expected %0d got %0d", $time, want.row, out_row);
				mismatch_count++;
			end
			if (out_col !== want.col) begin
				$display("%0t: out_col expected %0d got %0d", $time, want.col, out_col);
				mismatch_count++;
			end
		end
	endtask

	initial begin : edge_sink
		int hold_left;
		bit pressed;
		hold_left = 0;
		pressed = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) check_edge();
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!pressed && got_count >= PRESSURE_AT) begin
				pressed = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_window() && ($urandom_range(99) < 16);
			end
		end
	end

	initial begin : pixel_source
		dir_row_t                  rw;
		bit                        emitted;
		edge_beat_t                res;
		int                        rnd_items;
		int                        sel;
		int                        which;
		int                        n;
		bit                        do_w;
		bit                        do_h;
		logic [sgm_pkg::CFG_W-1:0] w_data;
		logic [sgm_pkg::CFG_W-1:0] h_data;
		rnd_items = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pixel <= '0;
		cfg_write <= 1'b0;
		cfg_index <= sgm_pkg::REG_IMAGE_WIDTH;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i]) begin
			rw = DIR_ROWS[i];
			case (rw.kind)
				DIR_WIDTH, DIR_HEIGHT: begin
					drain_block();
					write_reg(rw.kind == DIR_WIDTH ? sgm_pkg::REG_IMAGE_WIDTH
						: sgm_pkg::REG_IMAGE_HEIGHT, rw.value);
				end
				default: begin
					feed_pixel(rw.value[sgm_pkg::PIX_W-1:0], emitted, res);
					if (rw.kind == DIR_GIVEN) pending_edges.push_back(rw.want);
					else if (rw.kind == DIR_MODEL && emitted) pending_edges.push_back(res);
				end
			endcase
		end

		// oversized line, shrink in mid-line, grow in mid-frame, oversized frame
		resize(13'd4095, 13'd3, 1'b1, 1'b1);
		run_pixels(40, STYLE_NOISE);
		resize(13'd5, 13'd4, 1'b1, 1'b1);
		run_pixels(30, STYLE_STEPS);
		resize(13'd40, 13'd4096, 1'b1, 1'b1);
		run_pixels(40, STYLE_SMOOTH);
		resize(13'd3, 13'd8191, 1'b1, 1'b1);
		run_pixels(60, STYLE_NOISE);

		while (rnd_items < RANDOM_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 10) w_data = sgm_pkg::CFG_W'($urandom_range(2));
			else if (sel < 15) w_data = sgm_pkg::CFG_W'($urandom_range(4095, 2049));
			else if (sel < 22) w_data = sgm_pkg::CFG_W'($urandom_range(200, 13));
			else w_data = sgm_pkg::CFG_W'($urandom_range(12, 3));
			if ($urandom_range(9) == 0) w_data[sgm_pkg::CFG_W-1] = 1'b1;
			sel = $urandom_range(99);
			if (sel < 10) h_data = sgm_pkg::CFG_W'($urandom_range(2));
			else if (sel < 14) h_data = sgm_pkg::CFG_W'($urandom_range(8191, 4097));
			else if (sel < 20) h_data = sgm_pkg::CFG_W'($urandom_range(200, 9));
			else h_data = sgm_pkg::CFG_W'($urandom_range(8, 3));
			which = $urandom_range(9);
			do_w = (which <= 7);
			do_h = (which != 7);
			if (width_reads_unwritten(w_data, h_data, do_w, do_h)) begin
				w_data = sgm_pkg::CFG_W'(fill_w);
				do_w = 1'b1;
			end
			resize(w_data, h_data, do_w, do_h);
			n = $urandom_range(90, 10);
			run_pixels(n, pix_style_t'($urandom_range(3)));
			rnd_items += n;
		end

		drain_block();
		if (mismatch_count == 0) begin
			$display("sobel_gradient_magnitude test passed");
		end else begin
			$display("sobel_gradient_magnitude test failed");
		end
		$finish;
	end

endmodule
